[sv/brlf_pkg.sv]
package brlf_pkg;

	localparam int unsigned THR_W = 12;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned ENGAGE_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W = 48;
	localparam int unsigned OUT_DATA_W = 8;

	localparam logic [TIME_W-1:0] DEBOUNCE_MS = TIME_W'(50);
	localparam logic [TIME_W-1:0] FWD_ARM_MS = TIME_W'(120);
	localparam logic [TIME_W-1:0] TRIP_CLEAR_MS = TIME_W'(400);

	localparam logic [THR_W-1:0] BRAKE_REVERSE_HIGH_RST = THR_W'(1450);
	localparam logic [THR_W-1:0] FORWARD_LOW_RST = THR_W'(1550);
	localparam logic [ENGAGE_W-1:0] REVERSE_ENGAGE_RST = ENGAGE_W'(500);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRAKE_REVERSE_HIGH = 2'd0,
		REG_FORWARD_LOW        = 2'd1,
		REG_REVERSE_ENGAGE     = 2'd2,
		REG_UNUSED             = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_EVALUATE = 1'b0,
		REQ_RESET    = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_NEUTRAL = 2'd0,
		ST_FORWARD = 2'd1,
		ST_REVERSE = 2'd2,
		ST_BRAKE   = 2'd3
	} drive_t;

	typedef enum logic [1:0] {
		BAND_NONE    = 2'd0,
		BAND_BRK_REV = 2'd1,
		BAND_IDLE    = 2'd2,
		BAND_FWD     = 2'd3
	} band_t;

	typedef struct packed {
		drive_t              held_state;
		band_t               held_band;
		logic [TIME_W-1:0]   held_time;
		logic [TIME_W-1:0]   forward_since;
		logic [TIME_W-1:0]   shared_since;
		logic [TIME_W-1:0]   left_shared_at;
		logic                forward_trip;
		band_t               reported_band;
	} lamp_state_t;

	typedef struct packed {
		logic [THR_W-1:0]    brake_reverse_high;
		logic [THR_W-1:0]    forward_low;
		logic [ENGAGE_W-1:0] reverse_engage_ms;
	} lamp_cfg_t;

	typedef struct packed {
		logic   trip_armed;
		band_t  band_seen;
		drive_t drive_state;
		logic   reverse_on;
		logic   brake_on;
	} lamp_result_t;

	// set timer plus span, wrapped to 32 bits, has been reached
	function automatic logic elapsed(input logic [TIME_W-1:0] since,
			input logic [TIME_W-1:0] span, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] due;
		due = since + span;
		return (since != '0) && (due <= now);
	endfunction

endpackage

[sv/brlf_eval.sv]
module brlf_eval
	import brlf_pkg::*;
(
	input  lamp_cfg_t          cfg,
	input  lamp_state_t        cur,
	input  req_t               req_type,
	input  logic [THR_W-1:0]   throttle,
	input  logic [TIME_W-1:0]  now_ms,
	output lamp_state_t        nxt,
	output lamp_result_t       res
);

	logic [TIME_W-1:0] held_time_fix;
	logic [TIME_W-1:0] debounce_due;
	logic [TIME_W-1:0] forward_since_n;
	logic [TIME_W-1:0] shared_since_n;
	logic              trip_fwd;
	logic              debounced;
	band_t             band;
	drive_t            st;

	always_comb begin
		if (throttle <= cfg.brake_reverse_high) begin
			band = BAND_BRK_REV;
		end else if (throttle < cfg.forward_low) begin
			band = BAND_IDLE;
		end else begin
			band = BAND_FWD;
		end

		// pull held time back when the clock went backwards
		held_time_fix = (cur.held_time > now_ms) ? now_ms : cur.held_time;
		debounce_due = held_time_fix + DEBOUNCE_MS;
		debounced = (band == cur.held_band) && (debounce_due > now_ms);

		forward_since_n = '0;
		trip_fwd = cur.forward_trip;
		if (band == BAND_FWD) begin
			forward_since_n = (cur.forward_since == '0) ? now_ms : cur.forward_since;
			if (elapsed(forward_since_n, FWD_ARM_MS, now_ms)) begin
				trip_fwd = 1'b1;
			end
		end

		nxt = cur;
		nxt.held_time = held_time_fix;
		shared_since_n = '0;

		if (band == BAND_BRK_REV) begin
			shared_since_n = (cur.shared_since == '0) ? now_ms : cur.shared_since;
			nxt.left_shared_at = '0;
			nxt.forward_trip = trip_fwd;
		end else if (cur.left_shared_at == '0) begin
			nxt.left_shared_at = now_ms;
			nxt.forward_trip = trip_fwd;
		end else begin
			nxt.left_shared_at = cur.left_shared_at;
			nxt.forward_trip = elapsed(cur.left_shared_at, TRIP_CLEAR_MS, now_ms)
				? 1'b0 : trip_fwd;
		end

		if (band == BAND_FWD) begin
			st = ST_FORWARD;
		end else if (band != BAND_BRK_REV) begin
			st = ST_NEUTRAL;
		end else if (!nxt.forward_trip) begin
			st = ST_REVERSE;
		end else if (elapsed(shared_since_n, TIME_W'(cfg.reverse_engage_ms), now_ms)) begin
			st = ST_REVERSE;
		end else begin
			st = ST_BRAKE;
		end

		nxt.forward_since = forward_since_n;
		nxt.shared_since = shared_since_n;
		nxt.held_state = st;
		nxt.held_band = band;
		nxt.held_time = now_ms;
		nxt.reported_band = band;

		// debounced sample: only the held time correction survives
		if (debounced) begin
			nxt = cur;
			nxt.held_time = held_time_fix;
		end

		// reset request keeps held band and held time untouched
		if (req_type == REQ_RESET) begin
			nxt = cur;
			nxt.forward_trip = 1'b0;
			nxt.forward_since = '0;
			nxt.shared_since = '0;
			nxt.left_shared_at = '0;
			nxt.held_state = ST_NEUTRAL;
			nxt.reported_band = BAND_NONE;
		end

		res.brake_on = (nxt.held_state == ST_BRAKE);
		res.reverse_on = (nxt.held_state == ST_REVERSE);
		res.drive_state = nxt.held_state;
		res.band_seen = nxt.reported_band;
		res.trip_armed = nxt.forward_trip;
		if (req_type == REQ_RESET) begin
			res = '0;
		end
	end

endmodule

[sv/brake_reverse_lamp_fsm_core.sv]
// Brake and reverse lamp controller for a throttle channel whose low band is
// shared by braking and reversing.
// Input stream: one request per sample. tuser is the request kind (evaluate
// or reset); tdata carries the throttle pulse width and a wrapping
// millisecond timestamp. Each request yields exactly one result on the
// output stream with the lamp drives, drive state, band and trip flag.
// Data path: an accepted request sits in the input register, is evaluated
// against the held state and is captured in the result register when that
// register is empty or its result is taken; tvalid rises with the capture.
// Throughput: one request per cycle while the receiver keeps tready high;
// the state update is a single pass of compares and 32-bit adds between
// the input and result registers. When the receiver stalls, the result
// register holds; the input register still takes one more request, then
// tready drops until the result drains. Reset clears the handshake, the
// lamp state and the timers, and loads the threshold registers with their
// defaults. The user writes registers through the cfg port only while no
// request is in flight; the block does not enforce it; an unknown index is ignored.
module brake_reverse_lamp_fsm_core
	import brlf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // throttle[11:0], now_ms[43:12], zero pad
	input  logic                   s_axis_tuser,  // req_type
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata   // brake_on, reverse_on, drive_state[3:2],
	                                              // band_seen[5:4], trip_armed, zero pad
);

	lamp_cfg_t         cfg_q;
	lamp_state_t       state_q;
	lamp_state_t       state_nxt;
	lamp_result_t      res_nxt;
	lamp_result_t      res_s2;
	logic              valid_s1;
	logic              valid_s2;
	req_t              req_s1;
	logic [THR_W-1:0]  thr_s1;
	logic [TIME_W-1:0] now_s1;
	logic              advance;
	logic              take;

	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brake_reverse_high <= BRAKE_REVERSE_HIGH_RST;
			cfg_q.forward_low <= FORWARD_LOW_RST;
			cfg_q.reverse_engage_ms <= REVERSE_ENGAGE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BRAKE_REVERSE_HIGH: cfg_q.brake_reverse_high <= cfg_data[THR_W-1:0];
				REG_FORWARD_LOW:        cfg_q.forward_low <= cfg_data[THR_W-1:0];
				REG_REVERSE_ENGAGE:     cfg_q.reverse_engage_ms <= cfg_data[ENGAGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req_t'(s_axis_tuser);
			thr_s1 <= s_axis_tdata[THR_W-1:0];
			now_s1 <= s_axis_tdata[THR_W+TIME_W-1:THR_W];
		end
	end

	brlf_eval u_eval (
		.cfg      (cfg_q),
		.cur      (state_q),
		.req_type (req_s1),
		.throttle (thr_s1),
		.now_ms   (now_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{held_state: ST_NEUTRAL, held_band: BAND_NONE,
				reported_band: BAND_NONE, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// hold the result while the receiver stalls
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {1'b0, res_s2};

endmodule

[tb/brake_reverse_lamp_fsm_core_tb.sv]
`timescale 1ns / 1ps

module brake_reverse_lamp_fsm_core_tb;
	import brlf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_REQS = 100;
	localparam int PHASES = 8;

	typedef struct packed {
		req_t              kind;
		logic [THR_W-1:0]  throttle;
		logic [TIME_W-1:0] now_ms;
	} lamp_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // throttle[11:0], now_ms[43:12], zero pad
	logic                  s_axis_tuser = 1'b0; // req_type
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;       // brake_on, reverse_on, drive_state[3:2],
	                                           // band_seen[5:4], trip_armed, zero pad

	brake_reverse_lamp_fsm_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// lamp controller state as predicted
	logic [THR_W-1:0]    cfg_brh;
	logic [THR_W-1:0]    cfg_fwd_low;
	logic [ENGAGE_W-1:0] cfg_engage;
	drive_t              ps_held_state;
	band_t               ps_held_band;
	logic [TIME_W-1:0]   ps_held_time;
	logic [TIME_W-1:0]   ps_fwd_since;
	logic [TIME_W-1:0]   ps_shared_since;
	logic [TIME_W-1:0]   ps_left_at;
	logic                ps_trip;
	band_t               ps_rep_band;

	lamp_req_t    pending_reqs[$];
	lamp_result_t lamp_expected[$];
	lamp_req_t    req_on_bus;
	int           mismatches = 0;
	int           send_gap = 0;
	int           send_calm = 0;
	int           recv_gap = 0;
	int           recv_calm = 0;
	int           quiet_cycles = 0;

	// a timer of zero is unset; the sum wraps at 32 bits before the compare
	function automatic logic timer_due(input logic [TIME_W-1:0] since,
			input logic [TIME_W-1:0] span, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] due;
		due = since + span;
		return (since != '0) && (due <= now);
	endfunction

	function automatic lamp_result_t lamp_step(input lamp_req_t rq);
		lamp_result_t      res;
		band_t             band;
		drive_t            st;
		logic [TIME_W-1:0] window_end;
		if (rq.kind == REQ_RESET) begin
			ps_trip = 1'b0;
			ps_fwd_since = '0;
			ps_shared_since = '0;
			ps_left_at = '0;
			ps_held_state = ST_NEUTRAL;
			ps_rep_band = BAND_NONE;
			return '0;
		end
		if (ps_held_time > rq.now_ms)
			ps_held_time = rq.now_ms;
		if (rq.throttle <= cfg_brh)
			band = BAND_BRK_REV;
		else if (rq.throttle < cfg_fwd_low)
			band = BAND_IDLE;
		else
			band = BAND_FWD;
		window_end = ps_held_time + DEBOUNCE_MS;
		// same band inside the debounce window: keep everything
		if (!(band == ps_held_band && window_end > rq.now_ms)) begin
			if (band == BAND_FWD) begin
				if (ps_fwd_since == '0)
					ps_fwd_since = rq.now_ms;
				if (timer_due(ps_fwd_since, FWD_ARM_MS, rq.now_ms))
					ps_trip = 1'b1;
			end else begin
				ps_fwd_since = '0;
			end
			if (band == BAND_BRK_REV) begin
				if (ps_shared_since == '0)
					ps_shared_since = rq.now_ms;
				ps_left_at = '0;
			end else begin
				ps_shared_since = '0;
				if (ps_left_at == '0)
					ps_left_at = rq.now_ms;
				else if (timer_due(ps_left_at, TRIP_CLEAR_MS, rq.now_ms))
					ps_trip = 1'b0;
			end
			if (band == BAND_FWD)
				st = ST_FORWARD;
			else if (band != BAND_BRK_REV)
				st = ST_NEUTRAL;
			else if (!ps_trip)
				st = ST_REVERSE;
			else if (timer_due(ps_shared_since, {16'b0, cfg_engage}, rq.now_ms))
				st = ST_REVERSE;
			else
				st = ST_BRAKE;
			ps_held_state = st;
			ps_held_band = band;
			ps_held_time = rq.now_ms;
			ps_rep_band = band;
		end
		res.brake_on = (ps_held_state == ST_BRAKE);
		res.reverse_on = (ps_held_state == ST_REVERSE);
		res.drive_state = ps_held_state;
		res.band_seen = ps_rep_band;
		res.trip_armed = ps_trip;
		return res;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// throttle inside a band (0 shared, 1 neutral, 2 forward), edges often
	function automatic logic [THR_W-1:0] pick_throttle(input int which);
		int lo;
		int hi;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return THR_W'($urandom());
		if (which == 0) begin
			lo = 0;
			hi = cfg_brh;
		end else if (which == 1) begin
			lo = cfg_brh + 1;
			hi = cfg_fwd_low - 1;
		end else begin
			lo = (cfg_fwd_low > cfg_brh) ? cfg_fwd_low : cfg_brh + 1;
			hi = 4095;
		end
		if (lo > hi)
			return THR_W'($urandom());
		if (r < 25)
			return THR_W'(lo);
		if (r < 40)
			return THR_W'(hi);
		return THR_W'($urandom_range(hi, lo));
	endfunction

	task automatic push_req(input req_t kind, input int thr, input logic [TIME_W-1:0] now);
		lamp_req_t rq;
		rq.kind = kind;
		rq.throttle = THR_W'(thr);
		rq.now_ms = now;
		pending_reqs.push_back(rq);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BRAKE_REVERSE_HIGH: cfg_brh = val[THR_W-1:0];
			REG_FORWARD_LOW:        cfg_fwd_low = val[THR_W-1:0];
			REG_REVERSE_ENGAGE:     cfg_engage = val[ENGAGE_W-1:0];
			default: ;
		endcase
	endtask

	// upper bits of the 12-bit registers carry junk that must be dropped
	task automatic set_thresholds(input int brh, input int fwd_low, input int engage);
		cfg_write(REG_BRAKE_REVERSE_HIGH, {4'($urandom()), THR_W'(brh)});
		cfg_write(REG_FORWARD_LOW, {4'($urandom()), THR_W'(fwd_low)});
		cfg_write(REG_REVERSE_ENGAGE, ENGAGE_W'(engage));
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_axis_tvalid || lamp_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// dwell in one band for a while with mostly small time steps
	task automatic queue_drive_cycle(input int n);
		logic [TIME_W-1:0] t;
		int                made;
		int                which;
		int                dwell;
		int                r;
		t = $urandom();
		if ($urandom_range(0, 3) == 0)
			t = 32'hFFFF_FFFF - $urandom_range(0, 3000);
		made = 0;
		while (made < n) begin
			which = $urandom_range(0, 2);
			dwell = $urandom_range(1, 10);
			for (int k = 0; k < dwell && made < n; k++) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					push_req(REQ_RESET, $urandom(), $urandom());
				end else begin
					r = $urandom_range(0, 99);
					if (r < 60)
						t = t + $urandom_range(0, 70);
					else if (r < 85)
						t = t + $urandom_range(71, 200);
					else if (r < 94)
						t = t + $urandom_range(201, 800);
					else if (r < 97)
						t = t + $urandom_range(0, 70000);
					else if (r < 99)
						t = t - $urandom_range(1, 500);
					else
						t = $urandom();
					push_req(REQ_EVALUATE, pick_throttle(which), t);
				end
				made++;
			end
		end
	endtask

	// request side: one request at a time, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= REQ_EVALUATE;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				lamp_expected.push_back(lamp_step(req_on_bus));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req_on_bus = pending_reqs.pop_front();
					s_axis_tdata <= {4'b0, req_on_bus.now_ms, req_on_bus.throttle};
					s_axis_tuser <= req_on_bus.kind;
					s_axis_tvalid <= 1'b1;
					if (send_calm > 0) begin
						send_calm--;
					end else begin
						send_gap = idle_gap();
						if ($urandom_range(0, 47) == 0)
							send_calm = $urandom_range(16, 64);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic note_mismatch(input string field, input int want, input int seen);
		$display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
		mismatches++;
	endtask

	// result side: random stalls, compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		lamp_result_t want;
		lamp_result_t seen;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen = m_axis_tdata[6:0];
				if (lamp_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, got 0x%02h", $time,
						m_axis_tdata);
					mismatches++;
				end else begin
					want = lamp_expected.pop_front();
					if (seen.brake_on !== want.brake_on)
						note_mismatch("brake_on", want.brake_on, seen.brake_on);
					if (seen.reverse_on !== want.reverse_on)
						note_mismatch("reverse_on", want.reverse_on, seen.reverse_on);
					if (seen.drive_state !== want.drive_state)
						note_mismatch("drive_state", want.drive_state, seen.drive_state);
					if (seen.band_seen !== want.band_seen)
						note_mismatch("band_seen", want.band_seen, seen.band_seen);
					if (seen.trip_armed !== want.trip_armed)
						note_mismatch("trip_armed", want.trip_armed, seen.trip_armed);
					if (m_axis_tdata[7] !== 1'b0)
						note_mismatch("pad bit", 0, m_axis_tdata[7]);
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (recv_calm > 0) begin
					recv_calm--;
				end else begin
					recv_gap = idle_gap();
					if ($urandom_range(0, 47) == 0)
						recv_calm = $urandom_range(16, 64);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("brake_reverse_lamp_fsm_core_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int brh;
		cfg_brh = BRAKE_REVERSE_HIGH_RST;
		cfg_fwd_low = FORWARD_LOW_RST;
		cfg_engage = REVERSE_ENGAGE_RST;
		ps_held_state = ST_NEUTRAL;
		ps_held_band = BAND_NONE;
		ps_held_time = '0;
		ps_fwd_since = '0;
		ps_shared_since = '0;
		ps_left_at = '0;
		ps_trip = 1'b0;
		ps_rep_band = BAND_NONE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// unknown index: must not disturb the default thresholds
		cfg_write(REG_UNUSED, 16'($urandom()));

		// first sample at time zero leaves the shared timer unset
		push_req(REQ_EVALUATE, 0, 32'd0);
		push_req(REQ_EVALUATE, 4095, 32'd1000);
		push_req(REQ_EVALUATE, 4095, 32'd1010);
		push_req(REQ_EVALUATE, 4095, 32'd1060);
		// forward held long enough: arm the trip
		push_req(REQ_EVALUATE, 4095, 32'd1130);
		push_req(REQ_EVALUATE, 1450, 32'd1200);
		push_req(REQ_EVALUATE, 1000, 32'd1220);
		push_req(REQ_EVALUATE, 1450, 32'd1700);
		push_req(REQ_EVALUATE, 1500, 32'd1760);
		push_req(REQ_EVALUATE, 1549, 32'd2100);
		push_req(REQ_EVALUATE, 1500, 32'd2160);
		// clock runs backward
		push_req(REQ_EVALUATE, 4095, 32'd2000);
		push_req(REQ_RESET, 4095, 32'hFFFF_FFFF);
		// forward hold across the 32-bit wrap
		push_req(REQ_EVALUATE, 1550, 32'hFFFF_FFC0);
		push_req(REQ_EVALUATE, 1550, 32'hFFFF_FFFF);
		push_req(REQ_EVALUATE, 0, 32'd5);
		push_req(REQ_RESET, 0, 32'd0);
		push_req(REQ_EVALUATE, 1451, 32'd100);
		push_req(REQ_EVALUATE, 1451, 32'd149);
		push_req(REQ_EVALUATE, 1451, 32'd150);
		wait_idle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_thresholds(BRAKE_REVERSE_HIGH_RST, FORWARD_LOW_RST, REVERSE_ENGAGE_RST);
				1: set_thresholds(0, 4095, 0);
				2: set_thresholds(4095, 0, 65535);
				3: set_thresholds(2000, 1000, $urandom_range(0, 300));
				4: set_thresholds(BRAKE_REVERSE_HIGH_RST, FORWARD_LOW_RST, 0);
				default: begin
					brh = $urandom_range(0, 3000);
					set_thresholds(brh, brh + $urandom_range(1, 600), $urandom_range(0, 1000));
				end
			endcase
			queue_drive_cycle(PHASE_REQS);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("brake_reverse_lamp_fsm_core_tb OK");
		else
			$display("brake_reverse_lamp_fsm_core_tb NOT OK");
		$finish;
	end

endmodule
